### hdl/shortest_process_next_scheduler_macros.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef SHORTEST_PROCESS_NEXT_SCHEDULER_MACROS_SVH
`define SHORTEST_PROCESS_NEXT_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPNS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SPNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler next-cycle check failed");

`endif

### hdl/spns_pkg.sv
package spns_pkg;

  // Field widths of the payload.
  localparam int ID_BITS = 8;
  localparam int TIME_BITS = 16;
  localparam int READY_DEPTH_DEF = 16;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Item command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [ID_BITS-1:0]   proc_id;
    logic [TIME_BITS-1:0] service_len;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic                 finished_valid;
    logic [ID_BITS-1:0]   finished_id;
    logic                 started_valid;
    logic                 active_valid;
    logic [ID_BITS-1:0]   active_id;
    logic                 all_idle;
    logic [TIME_BITS-1:0] now_tick;
  } result_t;

  // One ready-table entry as held in the table memory.
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] need;
    logic [TIME_BITS-1:0] order;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_TICK,
    S_SCAN,
    S_SCAN_TAIL,
    S_COMMIT,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic idx_clear;
    logic idx_inc;
    logic arr_step;
    logic tick;
    logic best_clear;
    logic scan_issue;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic idx_last;
    logic run_valid;
    logic run_finish;
  } ctrl_sts_t;

endpackage

### hdl/spns_ctrl.sv
module spns_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  arrive,
  input  spns_pkg::ctrl_sts_t   sts,
  output spns_pkg::ctrl_cmd_t   ctl,
  output logic                  busy
);

  spns_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spns_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      spns_pkg::S_IDLE: begin
        if (start) begin
          state_next = arrive ? spns_pkg::S_ARRIVE : spns_pkg::S_TICK;
        end
      end
      spns_pkg::S_ARRIVE: begin
        if (sts.slot_free || sts.idx_last) begin
          state_next = spns_pkg::S_EMIT;
        end
      end
      spns_pkg::S_TICK: begin
        // A scan is needed whenever the processor is free after this tick.
        if (!sts.run_valid || sts.run_finish) begin
          state_next = spns_pkg::S_SCAN;
        end else begin
          state_next = spns_pkg::S_EMIT;
        end
      end
      spns_pkg::S_SCAN: begin
        if (sts.idx_last) begin
          state_next = spns_pkg::S_SCAN_TAIL;
        end
      end
      spns_pkg::S_SCAN_TAIL: state_next = spns_pkg::S_COMMIT;
      spns_pkg::S_COMMIT:    state_next = spns_pkg::S_EMIT;
      spns_pkg::S_EMIT:      state_next = spns_pkg::S_IDLE;
      default:               state_next = spns_pkg::S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    ctl = '0;
    busy = 1'b1;
    unique case (state)
      spns_pkg::S_IDLE: begin
        busy = 1'b0;
        ctl.capture = start;
        ctl.idx_clear = start;
      end
      spns_pkg::S_ARRIVE: begin
        ctl.arr_step = 1'b1;
        ctl.idx_inc = !sts.slot_free;
      end
      spns_pkg::S_TICK: begin
        ctl.tick = 1'b1;
        ctl.idx_clear = 1'b1;
        ctl.best_clear = 1'b1;
      end
      spns_pkg::S_SCAN: begin
        ctl.scan_issue = 1'b1;
        ctl.idx_inc = 1'b1;
      end
      spns_pkg::S_SCAN_TAIL: begin
      end
      spns_pkg::S_COMMIT: begin
        ctl.commit = 1'b1;
      end
      spns_pkg::S_EMIT: begin
        ctl.emit = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### hdl/spns_datapath.sv
module spns_datapath #(
  parameter int READY_DEPTH = spns_pkg::READY_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spns_pkg::item_t      item,
  input  spns_pkg::ctrl_cmd_t  ctl,
  output spns_pkg::ctrl_sts_t  sts,
  output logic                 done,
  output spns_pkg::result_t    result
);

  localparam int IDX_W = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(READY_DEPTH - 1);

  // Ready table: occupancy flags in flops, entries in a memory.
  logic [READY_DEPTH-1:0]  used;
  spns_pkg::entry_t        mem [READY_DEPTH];
  spns_pkg::entry_t        rd_entry;

  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    cmp_valid;
  logic                    cmp_used;

  // Best candidate found so far in the current scan.
  logic                              best_found;
  logic [IDX_W-1:0]                  best_idx;
  logic [spns_pkg::ID_BITS-1:0]      best_id;
  logic [spns_pkg::TIME_BITS-1:0]    best_need;
  logic [spns_pkg::TIME_BITS-1:0]    best_age;

  // Scheduler state.
  logic [spns_pkg::TIME_BITS-1:0]    arrival_counter;
  logic [spns_pkg::TIME_BITS-1:0]    tick_count;
  logic                              run_valid;
  logic [spns_pkg::ID_BITS-1:0]      run_id;
  logic [spns_pkg::TIME_BITS-1:0]    run_need;
  logic [spns_pkg::TIME_BITS-1:0]    run_done;

  spns_pkg::item_t                   held;
  spns_pkg::result_t                 res;
  logic                              done_q;

  logic                              slot_free;
  logic [spns_pkg::TIME_BITS-1:0]    done_inc;
  logic                              run_finish;
  logic [spns_pkg::TIME_BITS-1:0]    cand_age;
  logic                              cand_better;

  assign slot_free = !used[idx];

  // The executed count saturates at the top of its range.
  assign done_inc = (run_done == spns_pkg::TIME_MAX) ? run_done : run_done + 1'b1;
  assign run_finish = done_inc >= run_need;

  // Candidate wins on shorter need, or on equal need and greater age.
  assign cand_age = arrival_counter - rd_entry.order;
  assign cand_better = cmp_valid && cmp_used &&
                       (!best_found || (rd_entry.need < best_need) ||
                        ((rd_entry.need == best_need) && (cand_age > best_age)));

  assign sts.slot_free = slot_free;
  assign sts.idx_last = (idx == IDX_LAST);
  assign sts.run_valid = run_valid;
  assign sts.run_finish = run_finish;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      arrival_counter <= '0;
      tick_count <= '0;
      run_valid <= 1'b0;
      done_q <= 1'b0;
      cmp_valid <= 1'b0;
      best_found <= 1'b0;
      idx <= '0;
    end else begin
      done_q <= ctl.emit;
      cmp_valid <= ctl.scan_issue;
      if (ctl.idx_clear) begin
        idx <= '0;
      end else if (ctl.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (ctl.arr_step && slot_free) begin
        used[idx] <= 1'b1;
        arrival_counter <= arrival_counter + 1'b1;
      end
      if (ctl.tick) begin
        tick_count <= tick_count + 1'b1;
        if (run_valid && run_finish) begin
          run_valid <= 1'b0;
        end
      end
      if (ctl.best_clear) begin
        best_found <= 1'b0;
      end else if (cand_better) begin
        best_found <= 1'b1;
      end
      if (ctl.commit && best_found) begin
        used[best_idx] <= 1'b0;
        run_valid <= 1'b1;
      end
    end
  end

  // Table memory write port.
  always_ff @(posedge clk) begin
    if (ctl.arr_step && slot_free) begin
      mem[idx] <= '{id: held.proc_id, need: held.service_len, order: arrival_counter};
    end
  end

  // Table memory read port.
  always_ff @(posedge clk) begin
    if (ctl.scan_issue) begin
      rd_entry <= mem[idx];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_used <= used[idx];
    cmp_idx <= idx;
    if (ctl.capture) begin
      held <= item;
    end
    if (cand_better) begin
      best_idx <= cmp_idx;
      best_id <= rd_entry.id;
      best_need <= rd_entry.need;
      best_age <= cand_age;
    end
    if (ctl.tick && run_valid) begin
      run_done <= done_inc;
    end
    if (ctl.commit && best_found) begin
      run_id <= best_id;
      run_need <= best_need;
      run_done <= '0;
    end
  end

  // Result beat, built up as the item is worked on.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      res <= '{now_tick: tick_count, default: '0};
    end
    if (ctl.arr_step && slot_free) begin
      res.accepted <= 1'b1;
    end
    if (ctl.tick && run_valid && run_finish) begin
      res.finished_valid <= 1'b1;
      res.finished_id <= run_id;
    end
    if (ctl.commit && best_found) begin
      res.started_valid <= 1'b1;
    end
    if (ctl.emit) begin
      res.active_valid <= run_valid;
      res.active_id <= run_valid ? run_id : '0;
      res.all_idle <= !run_valid;
    end
  end

  assign done = done_q;
  assign result = res;

endmodule

### hdl/shortest_process_next_scheduler.sv
// Non-preemptive shortest-process-next scheduler. An item is taken when start
// is high and busy is low; its result beat appears on result for exactly one
// cycle with done high, and the receiver cannot hold it off. An arrive keeps
// the block busy until it reaches the lowest free entry or the last slot,
// since the occupancy flags are searched one slot per cycle. A tick that
// leaves the processor busy does not scan the table. A tick that must dispatch
// reads the whole ready table (16 entries at the default depth) through its
// single memory read port, one entry per cycle, then commits the best entry.
module shortest_process_next_scheduler #(
  parameter int READY_DEPTH = spns_pkg::READY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  spns_pkg::item_t    item,
  output logic               busy,
  output logic               done,
  output spns_pkg::result_t  result
);

  spns_pkg::ctrl_cmd_t ctl;
  spns_pkg::ctrl_sts_t sts;

  spns_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .arrive (item.cmd == spns_pkg::CMD_ARRIVE),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  spns_datapath #(
    .READY_DEPTH (READY_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .sts    (sts),
    .done   (done),
    .result (result)
  );

endmodule

### hdl/spns_checker.sv
`include "shortest_process_next_scheduler_macros.svh"

module spns_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input spns_pkg::result_t  result
);

  // A result beat never lasts more than one cycle.
  `SPNS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

  // An accepted item keeps the block busy in the next cycle.
  `SPNS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // The block is free again when a result beat is shown.
  `SPNS_ASSERT_IMPLY(a_done_free, clk, rst, done, !busy)

  // Running and idle indications always disagree, and an idle id reads zero.
  `SPNS_ASSERT_IMPLY(a_active_idle, clk, rst, done,
    (result.active_valid != result.all_idle) &&
    (result.active_valid || (result.active_id == '0)))

endmodule

bind shortest_process_next_scheduler spns_checker u_spns_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = spns_pkg::READY_DEPTH_DEF;
  localparam int IDW = spns_pkg::ID_BITS;
  localparam int TW = spns_pkg::TIME_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_SHOWN = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  spns_pkg::item_t sched_in = '0;
  logic busy;
  logic done;
  spns_pkg::result_t sched_out;

  shortest_process_next_scheduler dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (sched_in),
    .busy  (busy),
    .done  (done),
    .result(sched_out)
  );

  always #10 clk = ~clk;

  // Predicted scheduler state: the ready table and the running process.
  logic           rdy_used  [DEPTH];
  logic [IDW-1:0] rdy_id    [DEPTH];
  logic [TW-1:0]  rdy_need  [DEPTH];
  logic [TW-1:0]  rdy_stamp [DEPTH];
  logic [TW-1:0]  arrivals;
  logic           run_on;
  logic [IDW-1:0] run_id;
  logic [TW-1:0]  run_need;
  logic [TW-1:0]  run_done;
  logic [TW-1:0]  ticks;

  spns_pkg::result_t expected_results[$];
  int idle_pct = 8;
  int mismatches = 0;
  int stall_cycles = 0;

  // Move the shortest waiting entry onto the processor; the oldest wins a tie.
  function automatic bit dispatch_shortest();
    int best;
    logic [TW-1:0] best_need;
    logic [TW-1:0] best_age;
    logic [TW-1:0] age;
    best = -1;
    best_need = '0;
    best_age = '0;
    for (int i = 0; i < DEPTH; i++) begin
      age = arrivals - rdy_stamp[i];
      if (rdy_used[i] && (best < 0 || rdy_need[i] < best_need ||
          (rdy_need[i] == best_need && age > best_age))) begin
        best = i;
        best_need = rdy_need[i];
        best_age = age;
      end
    end
    if (best < 0) return 1'b0;
    rdy_used[best] = 1'b0;
    run_on = 1'b1;
    run_id = rdy_id[best];
    run_need = rdy_need[best];
    run_done = '0;
    return 1'b1;
  endfunction

  // Apply one accepted beat to the predicted state and return its result.
  function automatic spns_pkg::result_t schedule_step(spns_pkg::item_t it);
    spns_pkg::result_t r;
    r = '0;
    r.now_tick = ticks;
    if (it.cmd == spns_pkg::CMD_ARRIVE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!rdy_used[i]) begin
          rdy_used[i] = 1'b1;
          rdy_id[i] = it.proc_id;
          rdy_need[i] = it.service_len;
          rdy_stamp[i] = arrivals;
          arrivals = arrivals + 1'b1;
          r.accepted = 1'b1;
          break;
        end
      end
    end else begin
      if (!run_on) begin
        r.started_valid = dispatch_shortest();
      end else begin
        if (run_done != spns_pkg::TIME_MAX) run_done = run_done + 1'b1;
        // A zero service time also completes after a single tick.
        if (run_done >= run_need) begin
          r.finished_valid = 1'b1;
          r.finished_id = run_id;
          run_on = 1'b0;
          run_id = '0;
          run_need = '0;
          run_done = '0;
          r.started_valid = dispatch_shortest();
        end
      end
      ticks = ticks + 1'b1;
    end
    r.active_valid = run_on;
    r.active_id = run_on ? run_id : '0;
    r.all_idle = !run_on;
    return r;
  endfunction

  function automatic spns_pkg::item_t make_beat(logic cmd, logic [IDW-1:0] id,
                                                logic [TW-1:0] need);
    spns_pkg::item_t it;
    it.cmd = cmd;
    it.proc_id = id;
    it.service_len = need;
    return it;
  endfunction

  function automatic spns_pkg::item_t random_tick();
    return make_beat(spns_pkg::CMD_TICK, IDW'($urandom), TW'($urandom));
  endfunction

  // Drive one beat at the falling edge, with random idle cycles in front of it.
  task automatic send_beat(spns_pkg::item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    sched_in <= it;
    do @(posedge clk); while (busy);
    expected_results.insert(expected_results.size(), schedule_step(it));
  endtask

  task automatic check_field(string name, logic [TW-1:0] exp_v,
                             logic [TW-1:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < MAX_SHOWN)
        $display("mismatch on %s at %0t: expected %0h, got %0h", name, $time, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin : check_results
    spns_pkg::result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("result beat with nothing expected at %0t", $time);
        mismatches++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        check_field("accepted", TW'(exp_r.accepted), TW'(sched_out.accepted));
        check_field("finished_valid", TW'(exp_r.finished_valid),
                    TW'(sched_out.finished_valid));
        check_field("finished_id", TW'(exp_r.finished_id), TW'(sched_out.finished_id));
        check_field("started_valid", TW'(exp_r.started_valid),
                    TW'(sched_out.started_valid));
        check_field("active_valid", TW'(exp_r.active_valid), TW'(sched_out.active_valid));
        check_field("active_id", TW'(exp_r.active_id), TW'(sched_out.active_id));
        check_field("all_idle", TW'(exp_r.all_idle), TW'(sched_out.all_idle));
        check_field("now_tick", exp_r.now_tick, sched_out.now_tick);
      end
    end
  end

  // Stop the run when neither side moves a beat for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Fill the table to the brim, then check tie breaking and the drop of a
  // beat that finds no free entry. A long job waits behind all shorter ones.
  task automatic test_fill_and_ties();
    send_beat(make_beat(spns_pkg::CMD_TICK, 8'hFF, 16'hFFFF));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h00, 16'h0000));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h11, 16'd2));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h22, 16'd2));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h33, 16'd1));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h44, 16'd2));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'hFF, 16'd40));
    for (int k = 0; k < 10; k++)
      send_beat(make_beat(spns_pkg::CMD_ARRIVE, IDW'(8'hA0 + k), 16'd3));
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h5A, 16'd1));
    repeat (3) send_beat(make_beat(spns_pkg::CMD_TICK, 8'h00, 16'h0000));
    // A freed entry is reused, and the newcomer queues behind older equals.
    send_beat(make_beat(spns_pkg::CMD_ARRIVE, 8'h66, 16'd2));
    repeat (2) send_beat(random_tick());
  endtask

  // Tick until the table drains and the processor falls idle.
  task automatic test_tick_wrap();
    bit pending;
    do begin
      send_beat(random_tick());
      pending = run_on;
      for (int i = 0; i < DEPTH; i++) pending = pending | rdy_used[i];
    end while (pending);
    repeat (3) send_beat(random_tick());
  endtask

  // Bursts of arrivals with short, often equal service times, runs of ticks,
  // and now and then a burst large enough to overflow the table.
  task automatic test_random_traffic(int beats, int pct);
    int sent;
    int burst;
    int pick;
    logic [TW-1:0] need;
    idle_pct = pct;
    sent = 0;
    while (sent < beats) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        burst = $urandom_range(14, 20);
        repeat (burst)
          send_beat(make_beat(spns_pkg::CMD_ARRIVE, IDW'($urandom),
                              TW'($urandom_range(0, 3))));
      end else if (pick < 40) begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          need = ($urandom_range(99) < 4) ? TW'($urandom_range(0, 64))
                                          : TW'($urandom_range(0, 6));
          send_beat(make_beat(spns_pkg::CMD_ARRIVE, IDW'($urandom), need));
        end
      end else begin
        burst = $urandom_range(1, 16);
        repeat (burst) send_beat(random_tick());
      end
      sent += burst;
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      rdy_used[i] = 1'b0;
      rdy_id[i] = '0;
      rdy_need[i] = '0;
      rdy_stamp[i] = '0;
    end
    arrivals = '0;
    run_on = 1'b0;
    run_id = '0;
    run_need = '0;
    run_done = '0;
    ticks = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_fill_and_ties();
    test_tick_wrap();
    test_random_traffic(350, 8);
    test_random_traffic(350, 59);
    test_random_traffic(350, 0);

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
